[rtl/mfh_pkg.sv]
// ----------------------------------------------------------------------------
// mfh_pkg
// shared constants, queue entry type and mixing helpers for the flow hash
// ----------------------------------------------------------------------------
package mfh_pkg;

  localparam int unsigned MaxKeyWords = 16;
  localparam int unsigned CntW        = 5;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCntW       = $clog2(QueueDepth + 1);

  localparam logic [CntW-1:0] MAX_WORDS = CntW'(MaxKeyWords);

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_N  = 32'he6546b64;
  localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

  // register indexes on the config port
  localparam logic REG_SEED = 1'b0;

  // one classified, pre-mixed key word
  typedef struct packed {
    logic [31:0]     kmix;
    logic [31:0]     addr_mix;
    logic            first;
    logic            fin;
    logic [CntW-1:0] cnt;
  } mfh_entry_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

[rtl/mfh_front.sv]
// ----------------------------------------------------------------------------
// mfh_front
// accepts key words, tracks key boundaries and runs the word premix
// ----------------------------------------------------------------------------
module mfh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         key_word_i,
  input  logic [31:0]         address_mix_i,
  input  logic                last_word_i,
  output logic                push_o,
  output mfh_pkg::mfh_entry_t push_data_o,
  input  logic                full_i
);
  import mfh_pkg::*;

  logic            in_key_q, in_key_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            a_v_q, a_v_d;
  logic [31:0]     a_prod_q;
  logic [31:0]     a_mix_q;
  logic            a_first_q;
  logic            a_fin_q;
  logic [CntW-1:0] a_cnt_q;

  logic       b_v_q, b_v_d;
  mfh_entry_t b_entry_q;

  logic            a_ready, b_ready, in_acc, b_ld;
  logic            first;
  logic            fin;
  logic [CntW-1:0] cnt_next;

  assign b_ready    = !b_v_q || !full_i;
  assign a_ready    = !a_v_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;
  assign b_ld       = a_v_q && b_ready;
  assign push_o     = b_v_q && !full_i;
  assign push_data_o = b_entry_q;

  // key boundary tracking
  always_comb begin
    first    = !in_key_q;
    cnt_next = first ? CntW'(1) : cnt_q + CntW'(1);
    fin      = last_word_i || (cnt_next >= MAX_WORDS);
    in_key_d = in_key_q;
    cnt_d    = cnt_q;
    if (in_acc) begin
      in_key_d = !fin;
      cnt_d    = fin ? '0 : cnt_next;
    end
  end

  always_comb begin
    a_v_d = a_v_q;
    if (in_acc) begin
      a_v_d = 1'b1;
    end else if (b_ld) begin
      a_v_d = 1'b0;
    end
    b_v_d = b_v_q;
    if (b_ld) begin
      b_v_d = 1'b1;
    end else if (push_o) begin
      b_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_key_q <= 1'b0;
      cnt_q    <= '0;
      a_v_q    <= 1'b0;
      b_v_q    <= 1'b0;
    end else begin
      in_key_q <= in_key_d;
      cnt_q    <= cnt_d;
      a_v_q    <= a_v_d;
      b_v_q    <= b_v_d;
    end
  end

  // first multiply, then rotate and second multiply
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_prod_q  <= key_word_i * MIX_C1;
      a_mix_q   <= address_mix_i;
      a_first_q <= first;
      a_fin_q   <= fin;
      a_cnt_q   <= cnt_next;
    end
    if (b_ld) begin
      b_entry_q.kmix     <= rotl15(a_prod_q) * MIX_C2;
      b_entry_q.addr_mix <= a_mix_q;
      b_entry_q.first    <= a_first_q;
      b_entry_q.fin      <= a_fin_q;
      b_entry_q.cnt      <= a_cnt_q;
    end
  end

`ifndef ASSERT_OFF
  // a key never runs past its word limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_key_q |-> (cnt_q < MAX_WORDS))
    else $error("word count reached limit with key still open");
`endif

endmodule

[rtl/mfh_queue.sv]
// ----------------------------------------------------------------------------
// mfh_queue
// short fifo between the premix front and the hash back end
// ----------------------------------------------------------------------------
module mfh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfh_pkg::mfh_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output mfh_pkg::mfh_entry_t pop_data_o,
  output logic                empty_o
);
  import mfh_pkg::*;

  mfh_entry_t        entries_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == QCntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != QCntW'(QueueDepth)) |->
      (QPtrW'(wr_ptr_q - rd_ptr_q) == QPtrW'(count_q)))
    else $error("fill count out of step with pointers");
`endif

endmodule

[rtl/mfh_back.sv]
// ----------------------------------------------------------------------------
// mfh_back
// folds premixed words into the running hash and runs the avalanche finish
// ----------------------------------------------------------------------------
module mfh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_i,
  input  logic                empty_i,
  input  mfh_pkg::mfh_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         hash_value_o
);
  import mfh_pkg::*;

  logic [31:0] run_q, run_d;

  logic        v1_q, v1_d;
  logic        v2_q, v2_d;
  logic        v3_q, v3_d;
  logic        ov_q, ov_d;
  logic [31:0] s1_q, s2_q, s3_q, o_hash_q;

  logic        s1_ready, s2_ready, s3_ready, o_ready;
  logic        s1_ld, s2_ld, s3_ld, o_ld;
  logic [31:0] h_in, h_x, h_new, f0;

  assign o_ready  = !ov_q || !out_stall_i;
  assign s3_ready = !v3_q || o_ready;
  assign s2_ready = !v2_q || s3_ready;
  assign s1_ready = !v1_q || s2_ready;

  assign pop_o = !empty_i && s1_ready;
  assign s1_ld = pop_o && entry_i.fin;
  assign s2_ld = v1_q && s2_ready;
  assign s3_ld = v2_q && s3_ready;
  assign o_ld  = v3_q && o_ready;

  // per-word hash step, times five as shift and add
  always_comb begin
    h_in  = entry_i.first ? (entry_i.addr_mix ^ seed_i) : run_q;
    h_x   = rotl13(h_in ^ entry_i.kmix);
    h_new = h_x + {h_x[29:0], 2'b00} + MIX_N;
    f0    = h_new ^ {25'd0, entry_i.cnt, 2'b00};
    run_d = pop_o ? h_new : run_q;
  end

  always_comb begin
    v1_d = s1_ld ? 1'b1 : (s2_ld ? 1'b0 : v1_q);
    v2_d = s2_ld ? 1'b1 : (s3_ld ? 1'b0 : v2_q);
    v3_d = s3_ld ? 1'b1 : (o_ld  ? 1'b0 : v3_q);
    ov_d = o_ld  ? 1'b1 : ((ov_q && !out_stall_i) ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      run_q <= run_d;
      v1_q  <= v1_d;
      v2_q  <= v2_d;
      v3_q  <= v3_d;
      ov_q  <= ov_d;
    end
  end

  // avalanche: xorshift, multiply, xorshift, multiply, xorshift
  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_q <= f0 ^ {16'd0, f0[31:16]};
    end
    if (s2_ld) begin
      s2_q <= s1_q * FIN_C1;
    end
    if (s3_ld) begin
      s3_q <= (s2_q ^ {13'd0, s2_q[31:13]}) * FIN_C2;
    end
    if (o_ld) begin
      o_hash_q <= s3_q ^ {16'd0, s3_q[31:16]};
    end
  end

  assign out_valid_o  = ov_q;
  assign hash_value_o = o_hash_q;

`ifndef ASSERT_OFF
  // a finished key always enters the finish pipe
  a_fin_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.fin) |=> v1_q)
    else $error("finished key lost before avalanche");
`endif

endmodule

[rtl/murmur3_flow_hash.sv]
// ----------------------------------------------------------------------------
// murmur3_flow_hash
// murmur3 32-bit hash of a flow key, one 32-bit key word per item
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_stall_o   key_word_i, address_mix_i, last_word_i
//  out       source     out_valid_o/out_stall_i hash_value_o
//  cfg       apb slave  psel/penable/pready     paddr, pwdata, prdata (seed_constant at 0)
//
//  one key word per cycle sustained while the output is not stalled; the per-word
//  hash update in the back end is the registered loop through the running hash
//  that sets this figure; from last word to hash the result passes 2 premix stages,
//  queue write, fold with first xorshift, 2 finish stages, out reg
//  reset clears key tracking, queue, pipeline valids and the seed register
//  front and back stall independently through the 4-entry queue; a stalled output
//  holds its hash, words keep draining into the back end until the finish stages
//  are full, then the queue and both premix stages fill before the input stalls
//
module murmur3_flow_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // key words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] key_word_i,
  input  logic [31:0] address_mix_i,
  input  logic        last_word_i,
  // hash results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfh_pkg::*;

  // seed constant register
  logic [31:0] seed_q, seed_d;
  logic        reg_idx;
  logic        cfg_wr;

  // front to queue
  logic       push;
  mfh_entry_t push_data;
  logic       q_full;

  // queue to back
  logic       pop;
  mfh_entry_t pop_data;
  logic       q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  // writes beyond the register list are dropped
  always_comb begin
    seed_d = seed_q;
    if (cfg_wr && (reg_idx == REG_SEED)) begin
      seed_d = pwdata;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEED: prdata = seed_q;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  // front: key boundaries and the two-multiply word premix
  mfh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_word_i    (key_word_i),
    .address_mix_i (address_mix_i),
    .last_word_i   (last_word_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (q_full)
  );

  // decoupling queue
  mfh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // back: hash fold, length xor, avalanche, output register
  mfh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .empty_i      (q_empty),
    .entry_i      (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// flow hash testbench
// drives key words with random gaps and random output stalls, predicts each
// finished hash in step with the accepted items and compares every result;
// the seed register is written and read back between traffic phases
// ----------------------------------------------------------------------------
module testbench;
  import mfh_pkg::*;

  // config port addresses: register index times four
  localparam logic [2:0] SEED_ADDR  = {REG_SEED, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;  // no register here, writes are dropped

  // cycles to let the pipeline empty after the last expected hash
  localparam int unsigned DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] addr_mix;
    logic        last;
  } key_item_t;

  // dut ports, all inputs known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] key_word_i    = '0;
  logic [31:0] address_mix_i = '0;
  logic        last_word_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] hash_value_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // key items waiting to be offered, and hashes waiting to come out
  key_item_t   words_to_send[$];
  logic [31:0] hash_expected[$];

  // predicted block state
  logic [31:0]     cfg_seed  = '0;
  logic [31:0]     acc_hash  = '0;
  logic [CntW-1:0] acc_words = '0;
  logic            key_open  = 1'b0;

  int          fail_count  = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          hold_cycles = 0;   // long receiver hold-off, counted down below
  logic        no_idle     = 1'b0;
  logic [31:0] want_hash;

  murmur3_flow_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_word_i    (key_word_i),
    .address_mix_i (address_mix_i),
    .last_word_i   (last_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hash_value_o  (hash_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // hash prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  // standard murmur3 avalanche
  function automatic logic [31:0] finish_hash(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 16);
    x = x * FIN_C1;
    x = x ^ (x >> 13);
    x = x * FIN_C2;
    return x ^ (x >> 16);
  endfunction

  // fold one accepted key word into the running hash; a closed key yields a hash
  task automatic fold_key_word(input logic [31:0] word, input logic [31:0] addr_mix,
                               input logic last);
    logic [31:0] k;
    logic [31:0] h;
    // first word of a key: seed from the address mix and the configured constant
    if (!key_open) begin
      acc_hash  = addr_mix ^ cfg_seed;
      acc_words = '0;
      key_open  = 1'b1;
    end
    k = word * MIX_C1;
    k = rotl(k, 15);
    k = k * MIX_C2;
    h = acc_hash ^ k;
    h = rotl(h, 13) * 32'd5 + MIX_N;
    acc_hash  = h;
    acc_words = acc_words + 1'b1;
    // marked last word, or the key has hit its word limit
    if (last || acc_words >= MAX_WORDS) begin
      h = h ^ {25'd0, acc_words, 2'b00};  // byte length
      hash_expected.push_back(finish_hash(h));
      acc_hash  = '0;
      acc_words = '0;
      key_open  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("mismatch on %s: got %08h, want %08h, at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // idle length: mostly none, some short, a few long
  function automatic int pick_idle();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // key word driver: offers queued items, holds them while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        fold_key_word(key_word_i, address_mix_i, last_word_i);
      end
      // a stalled item stays on the port unchanged
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          in_valid_i    <= 1'b1;
          key_word_i    <= words_to_send[0].word;
          address_mix_i <= words_to_send[0].addr_mix;
          last_word_i   <= words_to_send[0].last;
          void'(words_to_send.pop_front());
          gap_left = pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // hash monitor: checks every accepted hash, then picks the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (hash_expected.size() == 0) begin
          report_mismatch("unexpected hash", hash_value_o, '0);
        end else begin
          want_hash = hash_expected.pop_front();
          if (hash_value_o !== want_hash) report_mismatch("hash_value", hash_value_o, want_hash);
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_idle();
      end
    end
  end

  // long hold-off counter, armed from the stimulus process
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_word(input logic [31:0] word, input logic [31:0] addr_mix,
                                   input logic last);
    key_item_t it;
    it.word     = word;
    it.addr_mix = addr_mix;
    it.last     = last;
    words_to_send.push_back(it);
  endfunction

  // random traffic: mostly well-formed keys, some over-long runs, some loose words
  function automatic void queue_traffic(input int n_words);
    int count;
    int len;
    int unsigned r;
    count = 0;
    while (count < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // mostly short keys, now and then up to the word limit
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, MaxKeyWords);
        for (int i = 0; i < len; i++) add_word($urandom, $urandom, i == len - 1);
      end else if (r < 88) begin
        // no end mark: the word limit closes the key, the rest opens the next one
        len = $urandom_range(MaxKeyWords, MaxKeyWords + 4);
        for (int i = 0; i < len; i++) add_word($urandom, $urandom, 1'b0);
      end else begin
        len = 1;
        add_word($urandom, $urandom, 1'($urandom_range(0, 1)));
      end
      count += len;
    end
  endfunction

  // wait until everything queued has been taken and every hash has come out
  task automatic drain();
    @(negedge clk_i);
    while (words_to_send.size() != 0 || in_valid_i || hash_expected.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only the seed address holds a register
    if (addr == SEED_ADDR) cfg_seed = data;
  endtask

  task automatic check_seed_readback();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEED_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== cfg_seed) report_mismatch("seed readback", prdata, cfg_seed);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // seed comes out of reset as zero
    check_seed_readback();

    // directed: single-word keys at the field extremes
    add_word(32'h0, 32'h0, 1'b1);
    add_word(32'hffffffff, 32'hffffffff, 1'b1);
    // three-word key, address mix on later words must be ignored
    add_word(32'h12345678, 32'hdeadbeef, 1'b0);
    add_word(32'h00000000, 32'hffffffff, 1'b0);
    add_word(32'hffffffff, 32'h00000000, 1'b1);
    // over-long key: closed by the word limit without an end mark
    for (int i = 0; i < MaxKeyWords; i++) add_word($urandom, $urandom, 1'b0);
    // fresh key right after the forced close
    add_word(32'h80000001, 32'h7ffffffe, 1'b1);
    // key ending exactly at the limit with its end mark
    for (int i = 0; i < MaxKeyWords; i++) add_word($urandom, $urandom, i == MaxKeyWords - 1);
    drain();

    // top seed, plus a write to an empty address that must change nothing
    cfg_write(SEED_ADDR, 32'hffffffff);
    cfg_write(SPARE_ADDR, $urandom);
    check_seed_readback();
    add_word(32'h0, 32'h0, 1'b1);
    add_word(32'hffffffff, 32'hffffffff, 1'b1);
    queue_traffic(200);
    drain();

    // back-pressure: output held off while words keep coming, so the input stalls
    cfg_write(SEED_ADDR, $urandom);
    check_seed_readback();
    @(negedge clk_i);
    no_idle     = 1'b1;
    hold_cycles = 300;
    queue_traffic(150);
    drain();
    no_idle = 1'b0;

    // zero seed again after other values
    cfg_write(SEED_ADDR, 32'h0);
    check_seed_readback();
    queue_traffic(250);
    drain();

    // random seed, a stretch at full rate on both sides, then idling again
    cfg_write(SEED_ADDR, $urandom);
    check_seed_readback();
    @(negedge clk_i);
    no_idle = 1'b1;
    queue_traffic(100);
    drain();
    no_idle = 1'b0;
    queue_traffic(320);
    drain();

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

endmodule
